/* rtl/bmua_pkg.sv */
// ----------------------------------------------------------------------------
// bmua_pkg
// Shared types and constants of the byte map unit allocator.
// ----------------------------------------------------------------------------
package bmua_pkg;

  localparam int UnitShiftW = 4;
  localparam int RegionW    = 11;
  localparam int SizeW      = 23;
  localparam int OffsW      = 22;
  localparam int UsedW      = 11;
  localparam int PaddrW     = 4;
  localparam int PdataW     = 32;

  // ID written to the reserved units at format time.
  localparam int unsigned ReserveId = 5;

  localparam logic [UnitShiftW-1:0] UnitShiftRst = 4'd4;
  localparam logic [RegionW-1:0]    RegionRst    = 11'd1024;
  localparam logic [RegionW-1:0]    ReservedRst  = 11'd0;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_FORMAT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_BAD_OFFSET = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_UNIT_SHIFT = 2'd0,
    REG_REGION     = 2'd1,
    REG_RESERVED   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [UnitShiftW-1:0] unit_shift;
    logic [RegionW-1:0]    region_units;
    logic [RegionW-1:0]    reserved_units;
  } cfg_t;

endpackage

/* rtl/bmua_map_ram.sv */
// ----------------------------------------------------------------------------
// bmua_map_ram
// Owner map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmua_map_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bmua_cfg.sv */
// ----------------------------------------------------------------------------
// bmua_cfg
// APB register file holding unit size, region size and reserved count.
// ----------------------------------------------------------------------------
module bmua_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmua_pkg::PaddrW-1:0] paddr,
  input  logic [bmua_pkg::PdataW-1:0] pwdata,
  output logic [bmua_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output bmua_pkg::cfg_t              cfg_o
);
  import bmua_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_UNIT_SHIFT: cfg_d.unit_shift     = pwdata[UnitShiftW-1:0];
        REG_REGION:     cfg_d.region_units   = pwdata[RegionW-1:0];
        REG_RESERVED:   cfg_d.reserved_units = pwdata[RegionW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UNIT_SHIFT: prdata = PdataW'(cfg_q.unit_shift);
      REG_REGION:     prdata = PdataW'(cfg_q.region_units);
      REG_RESERVED:   prdata = PdataW'(cfg_q.reserved_units);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_shift     <= UnitShiftRst;
      cfg_q.region_units   <= RegionRst;
      cfg_q.reserved_units <= ReservedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bmua_engine.sv */
// ----------------------------------------------------------------------------
// bmua_engine
// Command sequencer: scans, fills, frees and formats the owner map.
// ----------------------------------------------------------------------------
module bmua_engine #(
  parameter int MapDepth = 1024,
  parameter int IdBits   = 8,
  localparam int AW = $clog2(MapDepth),
  localparam int NW = (AW + 1 > 11) ? AW + 1 : 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmua_pkg::cfg_t              cfg_i,
  input  logic                        start_i,
  input  logic [1:0]                  func_i,
  input  logic [bmua_pkg::SizeW-1:0]  size_i,
  input  logic [bmua_pkg::OffsW-1:0]  offset_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [bmua_pkg::OffsW-1:0]  offs_o,
  output logic [bmua_pkg::UsedW-1:0]  used_o,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [IdBits-1:0]           wdata_o,
  output logic [AW-1:0]               raddr_o,
  input  logic [IdBits-1:0]           rdata_i
);
  import bmua_pkg::*;

  localparam int XW = SizeW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(MapDepth - 1);
  localparam logic [NW-1:0] RstUnits =
    (MapDepth < 1024) ? NW'(MapDepth) : NW'(1024);
  localparam logic [IdBits-1:0] ResId = IdBits'(ReserveId);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_LEFT  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_RIGHT = 9'b000010000,
    S_FILL  = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FWALK = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [NW-1:0]     cur_q, cur_d, steps_q, steps_d, y_q, y_d, need_q, need_d;
  logic [NW-1:0]     rs_q, rs_d, cnt_q, cnt_d, rsv_q, rsv_d, hint_q, hint_d;
  logic [NW-1:0]     used_q, used_d;
  logic [IdBits-1:0] prev_q, prev_d, left_q, left_d, idr_q, idr_d;
  logic              end_q, end_d, inrun_q, inrun_d, reply_q, reply_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [OffsW-1:0]  offs_q, offs_d;

  logic [NW-1:0]     n_w, rsv_w, hint_c, pos0, rd_addr, cnext;
  logic [XW-1:0]     need_full;
  logic [OffsW-1:0]  free_bi;
  logic [NW:0]       fmt_hint, fill_hint;
  logic [IdBits-1:0] id_c;
  logic              at_end;

  // Units in force and the reserved count clipped to them.
  assign n_w   = (NW'(cfg_i.region_units) > NW'(MapDepth)) ? NW'(MapDepth)
                                                           : NW'(cfg_i.region_units);
  assign rsv_w = (NW'(cfg_i.reserved_units) > n_w) ? n_w : NW'(cfg_i.reserved_units);

  assign need_full = ({1'b0, size_i} + ((XW'(1) << cfg_i.unit_shift) - XW'(1)))
                     >> cfg_i.unit_shift;
  assign free_bi   = offset_i >> cfg_i.unit_shift;
  assign hint_c    = (hint_q >= n_w) ? n_w - NW'(1) : hint_q;
  assign pos0      = ((hint_c + NW'(1)) >= n_w) ? '0 : hint_c + NW'(1);
  assign at_end    = (cur_q + NW'(1)) >= n_w;
  assign cnext     = at_end ? '0 : cur_q + NW'(1);

  always_comb begin
    logic [NW:0] v;
    v = {1'b0, rsv_q} + {1'b0, n_w} - (NW+1)'(1);
    if (n_w == '0) begin
      fmt_hint = '0;
    end else if (v >= {1'b0, n_w}) begin
      fmt_hint = v - {1'b0, n_w};
    end else begin
      fmt_hint = v;
    end
  end

  always_comb begin
    logic [NW:0] v;
    v = {1'b0, rs_q} + {1'b0, need_q} + {1'b0, n_w} - (NW+1)'(2);
    fill_hint = (v >= {1'b0, n_w}) ? v - {1'b0, n_w} : v;
  end

  // Next ID after the left neighbour that is neither zero nor the right one.
  always_comb begin
    logic [IdBits-1:0] right, c;
    right = end_q ? '0 : rdata_i;
    c = left_q + IdBits'(1);
    if (c == right || c == '0) c = c + IdBits'(1);
    if (c == right || c == '0) c = c + IdBits'(1);
    id_c = c;
  end

  always_comb begin
    logic [NW-1:0] s1, y1, c1;
    state_d  = state_q;
    cur_d    = cur_q;
    steps_d  = steps_q;
    y_d      = y_q;
    need_d   = need_q;
    rs_d     = rs_q;
    cnt_d    = cnt_q;
    rsv_d    = rsv_q;
    hint_d   = hint_q;
    used_d   = used_q;
    prev_d   = prev_q;
    left_d   = left_q;
    idr_d    = idr_q;
    end_d    = end_q;
    inrun_d  = inrun_q;
    reply_d  = reply_q;
    sweep_d  = sweep_q;
    status_d = status_q;
    offs_d   = offs_q;
    done_d   = 1'b0;
    we_o     = 1'b0;
    waddr_o  = cur_q[AW-1:0];
    wdata_o  = '0;
    rd_addr  = cur_q;
    s1       = '0;
    y1       = '0;
    c1       = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = ST_OK;
          offs_d   = '0;
          case (func_e'(func_i))
            FUNC_ALLOC: begin
              if (size_i == '0 || n_w == '0 || used_q >= n_w ||
                  XW'(n_w - used_q) < need_full) begin
                status_d = ST_NO_ROOM;
                done_d   = 1'b1;
              end else begin
                need_d  = NW'(need_full);
                cur_d   = pos0;
                rd_addr = (pos0 == '0) ? '0 : pos0 - NW'(1);
                steps_d = '0;
                y_d     = '0;
                inrun_d = 1'b0;
                state_d = S_LEFT;
              end
            end
            FUNC_FREE: begin
              if (free_bi >= OffsW'(n_w)) begin
                status_d = ST_BAD_OFFSET;
                done_d   = 1'b1;
              end else begin
                cur_d   = NW'(free_bi);
                rd_addr = NW'(free_bi);
                state_d = S_FRD;
              end
            end
            FUNC_FORMAT: begin
              rsv_d   = rsv_w;
              sweep_d = '0;
              reply_d = 1'b1;
              state_d = S_SWEEP;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SWEEP: begin
        we_o    = 1'b1;
        waddr_o = sweep_q;
        wdata_o = (NW'(sweep_q) < rsv_q) ? ResId : '0;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == LastIdx) begin
          state_d = S_IDLE;
          if (reply_q) begin
            hint_d   = NW'(fmt_hint);
            used_d   = rsv_q;
            status_d = ST_OK;
            offs_d   = '0;
            done_d   = 1'b1;
          end
        end
      end

      S_LEFT: begin
        prev_d  = rdata_i;
        rd_addr = cur_q;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        // Read data belongs to cur_q; the next unit is fetched meanwhile.
        rd_addr = cnext;
        prev_d  = rdata_i;
        end_d   = at_end;
        if (!inrun_q) begin
          if (rdata_i != '0) begin
            s1 = steps_q + NW'(1);
            if (s1 >= n_w) begin
              status_d = ST_NO_ROOM;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              steps_d = s1;
              cur_d   = cnext;
            end
          end else begin
            rs_d   = cur_q;
            left_d = (cur_q == '0) ? '0 : prev_q;
            if (need_q == NW'(1)) begin
              state_d = S_RIGHT;
            end else if (at_end) begin
              s1 = steps_q + NW'(1);
              if (s1 >= n_w) begin
                status_d = ST_NO_ROOM;
                done_d   = 1'b1;
                state_d  = S_IDLE;
              end else begin
                steps_d = s1;
                cur_d   = cnext;
              end
            end else begin
              inrun_d = 1'b1;
              y_d     = NW'(1);
              cur_d   = cnext;
            end
          end
        end else begin
          if (rdata_i == '0) begin
            y1 = y_q + NW'(1);
            if (y1 == need_q) begin
              state_d = S_RIGHT;
            end else if (at_end) begin
              s1 = steps_q + y1;
              if (s1 >= n_w) begin
                status_d = ST_NO_ROOM;
                done_d   = 1'b1;
                state_d  = S_IDLE;
              end else begin
                steps_d = s1;
                inrun_d = 1'b0;
                cur_d   = cnext;
              end
            end else begin
              y_d   = y1;
              cur_d = cnext;
            end
          end else begin
            // The run ends at a taken unit, which is then stepped over.
            s1 = steps_q + y_q + NW'(1);
            if (s1 >= n_w) begin
              status_d = ST_NO_ROOM;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              steps_d = s1;
              inrun_d = 1'b0;
              cur_d   = cnext;
            end
          end
        end
      end

      S_RIGHT: begin
        idr_d   = id_c;
        cur_d   = rs_q;
        y_d     = '0;
        state_d = S_FILL;
      end

      S_FILL: begin
        we_o    = 1'b1;
        wdata_o = idr_q;
        cur_d   = cur_q + NW'(1);
        y1      = y_q + NW'(1);
        y_d     = y1;
        if (y1 == need_q) begin
          hint_d   = NW'(fill_hint);
          used_d   = used_q + need_q;
          status_d = ST_OK;
          offs_d   = OffsW'(rs_q) << cfg_i.unit_shift;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_FRD: begin
        idr_d = rdata_i;
        if (rdata_i == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_addr = cur_q;
          cnt_d   = '0;
          state_d = S_FWALK;
        end
      end

      S_FWALK: begin
        c1 = cnt_q;
        if (rdata_i == idr_q) begin
          we_o = 1'b1;
          c1   = cnt_q + NW'(1);
        end
        cnt_d   = c1;
        cur_d   = cur_q + NW'(1);
        rd_addr = cur_q + NW'(1);
        if (rdata_i != idr_q || at_end) begin
          used_d  = (c1 > used_q) ? '0 : used_q - c1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign raddr_o = rd_addr[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      reply_q <= 1'b0;
      rsv_q   <= '0;
      hint_q  <= RstUnits - NW'(1);
      used_q  <= '0;
      inrun_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      reply_q <= reply_d;
      rsv_q   <= rsv_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      inrun_q <= inrun_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    y_q      <= y_d;
    need_q   <= need_d;
    rs_q     <= rs_d;
    cnt_q    <= cnt_d;
    prev_q   <= prev_d;
    left_q   <= left_d;
    idr_q    <= idr_d;
    end_q    <= end_d;
    status_q <= status_d;
    offs_q   <= offs_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign offs_o   = offs_q;
  assign used_o   = UsedW'(used_q);

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !we_o) else $error("map written during scan");

  a_scan_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (steps_q < n_w)) else $error("scan overran region");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (y_q < need_q)) else $error("fill overran run");

  a_free_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWALK) |-> (idr_q != '0)) else $error("free walk on zero ID");

endmodule

/* rtl/byte_map_unit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// byte_map_unit_allocator_unit
// Unit allocator over one region kept as a map of owner IDs, one per unit.
// ----------------------------------------------------------------------------
// A command word is taken with start while busy is low. func selects allocate,
// free or format; size_bytes and offset_bytes are sampled at that edge.
// Exactly one result word follows per command, shown for one cycle with done;
// the receiver cannot stall it and must capture it on that cycle.
// Allocate checks the free count, then scans the owner map one unit per cycle
// from just past the search hint, and writes the new run one unit per cycle.
// Requests rejected at the start answer in the cycle after they are taken.
// Free walks the run one unit per cycle, and format rewrites the whole map.
// These rates follow from the map memory's single write port and registered
// read. After reset the block clears the map with busy high; register writes
// on the APB port are taken during that time.
// Registers sit at byte addresses 0 (unit_shift), 4 (region_units) and 8
// (reserved_units) and must be written only while the block is idle.
module byte_map_unit_allocator_unit #(
  parameter int MAP_DEPTH = 1024,
  parameter int ID_BITS   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmua_pkg::PaddrW-1:0] paddr,
  input  logic [bmua_pkg::PdataW-1:0] pwdata,
  output logic [bmua_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [bmua_pkg::SizeW-1:0]  size_bytes_i,
  input  logic [bmua_pkg::OffsW-1:0]  offset_bytes_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [bmua_pkg::OffsW-1:0]  result_offset_o,
  output logic [bmua_pkg::UsedW-1:0]  units_in_use_o
);
  import bmua_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  cfg_t                cfg;
  logic                map_we;
  logic [AW-1:0]       map_waddr, map_raddr;
  logic [ID_BITS-1:0]  map_wdata, map_rdata;

  // Configuration registers.
  bmua_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer that reads, modifies and writes back the owner map.
  bmua_engine #(
    .MapDepth (MAP_DEPTH),
    .IdBits   (ID_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .start_i  (start),
    .func_i   (func_i),
    .size_i   (size_bytes_i),
    .offset_i (offset_bytes_i),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status_o),
    .offs_o   (result_offset_o),
    .used_o   (units_in_use_o),
    .we_o     (map_we),
    .waddr_o  (map_waddr),
    .wdata_o  (map_wdata),
    .raddr_o  (map_raddr),
    .rdata_i  (map_rdata)
  );

  // Owner map: one ID per unit.
  bmua_map_ram #(
    .Depth (MAP_DEPTH),
    .Width (ID_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

endmodule
